// ===== hw/rtl/fhm_pkg.sv =====
// ----------------------------------------------------------------------------
// fhm_pkg
// Types, codes and defaults shared by the FIFO handoff mutex modules.
// ----------------------------------------------------------------------------
package fhm_pkg;

  // field widths fixed by the word format
  localparam int TASK_W      = 6;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int COUNT_OUT_W = 5;

  // default waiter queue depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // request types
  localparam logic [REQ_W-1:0] REQ_LOCK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UNLOCK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HANDOFF   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CANCEL    = 3'd6;

  // input word
  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [TASK_W-1:0] task_id;
  } req_t;

  // result word
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   was_waiting;
    logic                   woken_valid;
    logic [TASK_W-1:0]      woken_task;
    logic                   owner_valid;
    logic [TASK_W-1:0]      owner_task;
    logic [COUNT_OUT_W-1:0] waiter_count;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic                latch;      // capture the incoming word
    logic                grant;      // take ownership for the latched task
    logic                enqueue;    // append latched task at the tail
    logic                release_m;  // free the mutex
    logic                head_rd;    // read the oldest waiter
    logic                handoff;    // pass ownership to the word read at the head
    logic                scan_start; // set up a cancel scan
    logic                scan_step;  // one scan and compaction step
    logic                scan_end;   // close the gap left by a removed waiter
    logic                fin;        // register the result word
    logic [STATUS_W-1:0] code;       // status code reported with fin
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             held;
    logic             is_owner;
    logic             empty;
    logic             full;
    logic             scan_last;
  } sts_t;

endpackage

// ===== hw/rtl/fhm_ram.sv =====
// ----------------------------------------------------------------------------
// fhm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fhm_ctrl.sv =====
// ----------------------------------------------------------------------------
// fhm_ctrl
// Sequencer for the mutex: decodes each word and steers the datapath.
// ----------------------------------------------------------------------------
module fhm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  fhm_pkg::sts_t sts,
  output fhm_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_HANDOFF = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_REPORT  = 3'd4;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  logic [fhm_pkg::STATUS_W-1:0] code;
  logic [fhm_pkg::STATUS_W-1:0] code_next;

  assign busy = (state != S_IDLE);

  // state and status code registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= fhm_pkg::ST_CANCEL;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  // next state and command decode
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_REPORT;
        unique case (sts.req_type)
          fhm_pkg::REQ_LOCK: begin
            if (!sts.held) begin
              cmd.grant = 1'b1;
              code_next = fhm_pkg::ST_GRANTED;
            end else if (!sts.full) begin
              cmd.enqueue = 1'b1;
              code_next   = fhm_pkg::ST_QUEUED;
            end else begin
              code_next = fhm_pkg::ST_FULL;
            end
          end
          fhm_pkg::REQ_UNLOCK: begin
            if (!sts.is_owner) begin
              code_next = fhm_pkg::ST_NOT_OWNER;
            end else if (sts.empty) begin
              cmd.release_m = 1'b1;
              code_next     = fhm_pkg::ST_FREED;
            end else begin
              cmd.head_rd = 1'b1;
              state_next  = S_HANDOFF;
            end
          end
          fhm_pkg::REQ_CANCEL: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          default: begin
            code_next = fhm_pkg::ST_CANCEL;
          end
        endcase
      end
      S_HANDOFF: begin
        cmd.handoff = 1'b1;
        code_next   = fhm_pkg::ST_HANDOFF;
        state_next  = S_REPORT;
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          cmd.scan_end = 1'b1;
          code_next    = fhm_pkg::ST_CANCEL;
          state_next   = S_REPORT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_REPORT: begin
        cmd.fin    = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/fhm_dp.sv =====
// ----------------------------------------------------------------------------
// fhm_dp
// Mutex datapath: owner registers, circular waiter queue in RAM, cancel
// scan with in-place compaction and the result register.
// ----------------------------------------------------------------------------
module fhm_dp #(
  parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  fhm_pkg::req_t req,
  input  fhm_pkg::cmd_t cmd,
  output fhm_pkg::sts_t sts,
  output logic          done,
  output fhm_pkg::rsp_t rsp
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = fhm_pkg::TASK_W;

  localparam logic [AW-1:0] LAST_ADDR = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(QUEUE_DEPTH);

  // latched word and owner
  fhm_pkg::req_t req_q;
  logic          held;
  logic [TW-1:0] holder;

  // queue pointers
  logic [AW-1:0] head;
  logic [CW-1:0] count;

  // scan state
  logic [AW-1:0] rd_pos;
  logic [CW-1:0] issued;
  logic          dv;
  logic [AW-1:0] d_addr;
  logic          found;
  logic [AW-1:0] hole;

  // ram ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [TW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [TW-1:0] rdata;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] rd_pos_inc;
  logic          issue;
  logic          hit;
  logic [31:0]   count_wide;

  fhm_ram #(
    .WIDTH (TW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // address arithmetic with wrap at the queue depth
  always_comb begin
    tail_sum   = (CW + 1)'(head) + (CW + 1)'(count);
    tail       = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);
    head_inc   = (head == LAST_ADDR) ? '0 : head + AW'(1);
    rd_pos_inc = (rd_pos == LAST_ADDR) ? '0 : rd_pos + AW'(1);
    issue      = cmd.scan_step && (issued != count);
    hit        = dv && !found && (rdata == req_q.task_id);
  end

  // ram port steering
  always_comb begin
    we    = 1'b0;
    waddr = tail;
    wdata = req_q.task_id;
    raddr = cmd.head_rd ? head : rd_pos;
    if (cmd.enqueue) begin
      we = 1'b1;
    end else if (cmd.scan_step && dv && found) begin
      we    = 1'b1;
      waddr = hole;
      wdata = rdata;
    end
  end

  // status to the controller
  always_comb begin
    sts.req_type  = req_q.req_type;
    sts.held      = held;
    sts.is_owner  = held && (holder == req_q.task_id);
    sts.empty     = (count == '0);
    sts.full      = (count == DEPTH_C);
    sts.scan_last = !dv && (issued == count);
  end

  // latched word, payload only
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_q <= req;
    end
  end

  // owner and queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 1'b0;
      holder <= '0;
      head   <= '0;
      count  <= '0;
    end else begin
      if (cmd.grant) begin
        held   <= 1'b1;
        holder <= req_q.task_id;
      end
      if (cmd.release_m) begin
        held   <= 1'b0;
        holder <= '0;
      end
      if (cmd.enqueue) begin
        count <= count + CW'(1);
      end
      if (cmd.handoff) begin
        holder <= rdata;
        head   <= head_inc;
        count  <= count - CW'(1);
      end
      if (cmd.scan_end && found) begin
        count <= count - CW'(1);
      end
    end
  end

  // cancel scan: read ahead one entry, shift entries behind the hole
  always_ff @(posedge clk) begin
    if (rst) begin
      dv    <= 1'b0;
      found <= 1'b0;
    end else begin
      if (cmd.latch) begin
        found <= 1'b0;
      end
      if (cmd.scan_start) begin
        dv <= 1'b0;
      end else if (cmd.scan_step) begin
        dv <= issue;
        if (hit) begin
          found <= 1'b1;
        end
      end
    end
  end

  // scan pointers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_pos <= head;
      issued <= '0;
    end else if (cmd.scan_step) begin
      if (issue) begin
        rd_pos <= rd_pos_inc;
        issued <= issued + CW'(1);
        d_addr <= rd_pos;
      end
      if (hit || (dv && found)) begin
        hole <= d_addr;
      end
    end
  end

  // result word
  assign count_wide = 32'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      rsp.status       <= cmd.code;
      rsp.was_waiting  <= (cmd.code == fhm_pkg::ST_CANCEL) && found;
      rsp.woken_valid  <= (cmd.code == fhm_pkg::ST_HANDOFF);
      rsp.woken_task   <= (cmd.code == fhm_pkg::ST_HANDOFF) ? holder : '0;
      rsp.owner_valid  <= held;
      rsp.owner_task   <= held ? holder : '0;
      rsp.waiter_count <= count_wide[fhm_pkg::COUNT_OUT_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/fifo_handoff_mutex.sv =====
// Lock, refused unlock and free go from accept through decide to report, then done.
// Handoff adds a state for the registered read of the oldest waiter.
// Cancel adds a scan before the report; the scan reads one queue entry per cycle.
// Throughput: busy drops as done rises, so a new word is taken in the done cycle.
// Reset: owner, queue pointers and waiter count clear synchronously; the queue RAM
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// fifo_handoff_mutex
// Hardware mutex with an ordered FIFO of waiting tasks and direct handoff.
// ----------------------------------------------------------------------------
module fifo_handoff_mutex #(
  parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  fhm_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output fhm_pkg::rsp_t rsp
);

  fhm_pkg::cmd_t cmd;
  fhm_pkg::sts_t sts;

  // sequencer
  fhm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // owner, queue and result datapath
  fhm_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cmd  (cmd),
    .sts  (sts),
    .done (done),
    .rsp  (rsp)
  );

`ifndef SYNTHESIS
  // a result word only ever closes an accepted request
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a request in progress");

  // an accepted word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not start work");

  // a free mutex reports no owner id
  a_free_no_owner: assert property (@(posedge clk) disable iff (rst)
    (done && !rsp.owner_valid) |-> (rsp.owner_task == '0))
    else $error("owner id reported while mutex free");

  // a woken waiter is the new owner
  a_woken_owns: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.woken_valid) |-> (rsp.owner_valid && (rsp.owner_task == rsp.woken_task)))
    else $error("woken task is not the owner");

  // a grant leaves the mutex held
  a_grant_held: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == fhm_pkg::ST_GRANTED)) |-> rsp.owner_valid)
    else $error("grant without ownership");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO handoff mutex. A short table of directed
// words opens the run, followed by phases of random lock, unlock, cancel and
// reserved words with varied mixes, sent in bursts with random gaps. Each
// result is checked by field against a typed row or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fhm_pkg::*;

  // request type with no defined action
  localparam logic [REQ_W-1:0] REQ_RSVD = 2'd3;
  localparam int DEPTH     = QUEUE_DEPTH_DEF;
  localparam int N_DIR     = 18;
  localparam int N_PHASE   = 8;
  localparam int PHASE_LEN = 105;

  // directed row: typed expectation used only when typed is set
  typedef struct packed {
    logic typed;
    req_t w;
    rsp_t want;
  } row_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  // predictor state
  logic              lock_held;
  logic [TASK_W-1:0] lock_holder;
  logic [TASK_W-1:0] wait_q[$];

  rsp_t        outcome_q[$];
  int          errors;
  int          burst_left;
  logic [TASK_W-1:0] pool_ids[8];

  row_t dir_rows[N_DIR] = '{
    '{1'b1, '{REQ_UNLOCK, 6'd5},  '{ST_NOT_OWNER, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0, 5'd0}},
    '{1'b1, '{REQ_CANCEL, 6'd0},  '{ST_CANCEL, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0, 5'd0}},
    '{1'b1, '{REQ_RSVD, 6'd63},   '{ST_CANCEL, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0, 5'd0}},
    '{1'b1, '{REQ_LOCK, 6'd63},   '{ST_GRANTED, 1'b0, 1'b0, 6'd0, 1'b1, 6'd63, 5'd0}},
    '{1'b0, '{REQ_LOCK, 6'd63},   '0},
    '{1'b0, '{REQ_LOCK, 6'd0},    '0},
    '{1'b0, '{REQ_LOCK, 6'd0},    '0},
    '{1'b0, '{REQ_LOCK, 6'd21},   '0},
    '{1'b0, '{REQ_UNLOCK, 6'd0},  '0},
    '{1'b0, '{REQ_CANCEL, 6'd63}, '0},
    '{1'b0, '{REQ_CANCEL, 6'd0},  '0},
    '{1'b0, '{REQ_CANCEL, 6'd21}, '0},
    '{1'b0, '{REQ_CANCEL, 6'd42}, '0},
    '{1'b0, '{REQ_RSVD, 6'd42},   '0},
    '{1'b0, '{REQ_UNLOCK, 6'd63}, '0},
    '{1'b1, '{REQ_UNLOCK, 6'd0},  '{ST_FREED, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0, 5'd0}},
    '{1'b1, '{REQ_LOCK, 6'd42},   '{ST_GRANTED, 1'b0, 1'b0, 6'd0, 1'b1, 6'd42, 5'd0}},
    '{1'b1, '{REQ_UNLOCK, 6'd42}, '{ST_FREED, 1'b0, 1'b0, 6'd0, 1'b0, 6'd0, 5'd0}}
  };

  fifo_handoff_mutex u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always #10 clk = ~clk;

  // mutex predictor: applies one accepted word and returns its result
  function automatic rsp_t apply_request(input req_t w);
    rsp_t r;
    int   hit;
    r = '0;
    r.status = ST_CANCEL;
    hit = -1;
    case (w.req_type)
      REQ_LOCK: begin
        if (!lock_held) begin
          lock_held   = 1'b1;
          lock_holder = w.task_id;
          r.status    = ST_GRANTED;
        end else if (wait_q.size() < DEPTH) begin
          wait_q.push_back(w.task_id);
          r.status = ST_QUEUED;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_UNLOCK: begin
        if (!lock_held || lock_holder != w.task_id) begin
          r.status = ST_NOT_OWNER;
        end else if (wait_q.size() == 0) begin
          lock_held   = 1'b0;
          lock_holder = '0;
          r.status    = ST_FREED;
        end else begin
          lock_holder   = wait_q.pop_front();
          r.woken_valid = 1'b1;
          r.woken_task  = lock_holder;
          r.status      = ST_HANDOFF;
        end
      end
      REQ_CANCEL: begin
        // first occurrence only, order of the rest kept
        for (int i = 0; i < wait_q.size(); i++) begin
          if (hit < 0 && wait_q[i] == w.task_id) hit = i;
        end
        if (hit >= 0) begin
          wait_q.delete(hit);
          r.was_waiting = 1'b1;
        end
      end
      default: ;
    endcase
    r.owner_valid  = lock_held;
    r.owner_task   = lock_held ? lock_holder : '0;
    r.waiter_count = COUNT_OUT_W'(wait_q.size());
    return r;
  endfunction

  // mostly a small pool of ids so that cancels and duplicates hit
  function automatic logic [TASK_W-1:0] pool_pick();
    if ($urandom_range(0, 3) == 0) return TASK_W'($urandom_range(0, 63));
    return pool_ids[3'($urandom_range(0, 7))];
  endfunction

  // random word shaped by the current mix and the predicted state
  function automatic req_t make_req(input int lw, input int uw, input int cw);
    req_t w;
    int   roll;
    roll = $urandom_range(0, 99);
    w.task_id = pool_pick();
    if (roll < lw) begin
      w.req_type = REQ_LOCK;
    end else if (roll < lw + uw) begin
      w.req_type = REQ_UNLOCK;
      if (lock_held && $urandom_range(0, 99) < 85) w.task_id = lock_holder;
    end else if (roll < lw + uw + cw) begin
      w.req_type = REQ_CANCEL;
      if (wait_q.size() > 0 && $urandom_range(0, 99) < 70)
        w.task_id = wait_q[$urandom_range(0, wait_q.size() - 1)];
    end else begin
      w.req_type = REQ_RSVD;
    end
    return w;
  endfunction

  // compare one field, x and z count as mismatches
  task automatic field_cmp(input string name, input logic [7:0] want,
                           input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // check one result word against the oldest expectation
  task automatic check_word(input rsp_t got);
    rsp_t want;
    if (outcome_q.size() == 0) begin
      errors++;
      $display("%0t: result word with none expected: expected none, actual %p",
               $time, got);
      return;
    end
    want = outcome_q.pop_front();
    field_cmp("status",       8'(want.status),       8'(got.status));
    field_cmp("was_waiting",  8'(want.was_waiting),  8'(got.was_waiting));
    field_cmp("woken_valid",  8'(want.woken_valid),  8'(got.woken_valid));
    field_cmp("woken_task",   8'(want.woken_task),   8'(got.woken_task));
    field_cmp("owner_valid",  8'(want.owner_valid),  8'(got.owner_valid));
    field_cmp("owner_task",   8'(want.owner_task),   8'(got.owner_task));
    field_cmp("waiter_count", 8'(want.waiter_count), 8'(got.waiter_count));
  endtask

  // sender pacing: bursts of words with random gaps, junk on req while idle
  task automatic issue(input req_t w, input logic typed, input rsp_t want);
    rsp_t pred;
    if (burst_left == 0) begin
      start <= 1'b0;
      req   <= req_t'($urandom);
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = apply_request(w);
    outcome_q.push_back(typed ? want : pred);
  endtask

  // result monitor, results cannot be held off
  always @(posedge clk) begin
    if (!rst && done) check_word(rsp);
  end

  // overall time limit
  initial begin
    #6_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // stimulus
  initial begin
    int lw;
    int uw;
    int cw;
    int guard;
    errors      = 0;
    burst_left  = 0;
    lock_held   = 1'b0;
    lock_holder = '0;
    pool_ids[0] = '0;
    pool_ids[1] = '1;
    for (int i = 2; i < 8; i++) pool_ids[i] = TASK_W'($urandom_range(0, 63));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i]) issue(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].want);

    // random phases with different mixes
    for (int ph = 0; ph < N_PHASE; ph++) begin
      case (ph % 4)
        0: begin lw = 40; uw = 35; cw = 20; end
        1: begin lw = 70; uw = 15; cw = 12; end
        2: begin lw = 30; uw = 25; cw = 42; end
        default: begin lw = 25; uw = 55; cw = 17; end
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        // lock-heavy phases open with a run of locks to fill the queue
        if (ph % 4 == 1 && n < 20) issue(make_req(100, 0, 0), 1'b0, '0);
        else issue(make_req(lw, uw, cw), 1'b0, '0);
      end
      // after every second phase, hold off until every outstanding result has come back
      if (ph % 2 == 1) begin
        start <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outcome_q.size() != 0) @(posedge clk);
      end
    end

    // drain
    start <= 1'b0;
    guard = 0;
    while (outcome_q.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    if (outcome_q.size() != 0) begin
      errors++;
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               outcome_q.size());
    end
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
